[hw/rtl/eorp_pkg.sv]
// Shared types, codes and field layout for the EDNS OPT record parser.
package eorp_pkg;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NSID_LENGTH     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOKIES_ENABLED = 1'b1;

  // Result queue depth
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Result tdata layout, lowest bit up
  localparam int OFF_STATUS    = 0;
  localparam int OFF_UDP_SIZE  = 2;
  localparam int OFF_DO        = 18;
  localparam int OFF_NSID      = 19;
  localparam int OFF_CK_STATUS = 20;
  localparam int OFF_CK_LENGTH = 22;
  localparam int OFF_RESERVED  = 28;
  localparam int OFF_CK_BYTE   = 44;
  localparam int OFF_CK_INDEX  = 52;

  // Header byte positions within the fixed part of the record
  localparam logic [3:0] HDR_OWNER    = 4'd0;
  localparam logic [3:0] HDR_TYPE_HI  = 4'd1;
  localparam logic [3:0] HDR_TYPE_LO  = 4'd2;
  localparam logic [3:0] HDR_CLASS_HI = 4'd3;
  localparam logic [3:0] HDR_CLASS_LO = 4'd4;
  localparam logic [3:0] HDR_VERSION  = 4'd6;
  localparam logic [3:0] HDR_FLAGS_HI = 4'd7;
  localparam logic [3:0] HDR_RDLEN_HI = 4'd9;
  localparam logic [3:0] HDR_RDLEN_LO = 4'd10;

  // Protocol constants
  localparam logic [7:0]  TYPE_OPT_CODE    = 8'd41;
  localparam logic [15:0] NSID_OPT_CODE    = 16'd3;
  localparam logic [15:0] COOKIE_OPT_CODE  = 16'd10;
  localparam logic [15:0] OPT_HEADER_LEN   = 16'd4;
  localparam logic [15:0] COOKIE_RESERVE   = 16'd24;
  localparam logic [15:0] RECORD_FIXED_LEN = 16'd11;
  localparam logic [15:0] COOKIE_LEN_CLIENT = 16'd8;
  localparam logic [15:0] COOKIE_LEN_MIN   = 16'd16;
  localparam logic [15:0] COOKIE_LEN_MAX   = 16'd40;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_OPTHDR  = 2'd2,
    PH_OPTDATA = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STAT_NOT_EDNS  = 2'd0,
    STAT_OK        = 2'd1,
    STAT_BAD_VERS  = 2'd2,
    STAT_MALFORMED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CK_ABSENT     = 2'd0,
    CK_INVALID    = 2'd1,
    CK_UNVERIFIED = 2'd2
  } ck_state_t;

  typedef struct packed {
    logic                   kind;
    logic                   last;
    logic [OUT_TDATA_W-1:0] data;
  } res_t;

  // Up to two results per accepted beat, a goes out first
  typedef struct packed {
    logic a_vld;
    logic b_vld;
    res_t a;
    res_t b;
  } push_t;

endpackage

[hw/rtl/eorp_parser.sv]
// Byte-wise OPT record parser: state update and result formatting per beat.
module eorp_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [7:0]                       data_byte,
  input  logic                             record_start,
  input  logic                             packet_end,
  input  logic                             cfg_we,
  input  logic [eorp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eorp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output eorp_pkg::push_t                  push
);
  import eorp_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  hdr_cnt;
    logic [15:0] rdata_left;
    logic [23:0] opt_hdr;
    logic [1:0]  opt_cnt;
    logic [15:0] opt_left;
    logic        is_cookie;
    logic [15:0] udp;
    logic        ver_bad;
    logic        do_bit;
    logic        nsid;
    ck_state_t   ck_state;
    logic [5:0]  ck_len;
    logic [15:0] space;
  } ctx_t;

  ctx_t        ctx_r, ctx_nxt, cur;
  logic [15:0] sid_size_r;
  logic        ck_en_r;

  logic        sum_vld, ck_vld;
  status_t     sum_st;
  logic [5:0]  ck_idx;
  logic [15:0] rl_dec, ol_dec, opt_code, opt_len, rsv;
  logic [31:0] full_hdr;
  logic [OUT_TDATA_W-1:0] sum_data, ck_data;

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [16:0] b);
    logic [17:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 18'd65535) ? 16'hFFFF : s[15:0];
  endfunction

  // Option boundary: finish the record or open the next option header
  function automatic logic boundary_done(logic [15:0] rl, output status_t st);
    st = STAT_OK;
    if (rl == 16'd0) begin
      return 1'b1;
    end
    if (rl < OPT_HEADER_LEN) begin
      st = STAT_MALFORMED;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sid_size_r <= '0;
      ck_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NSID_LENGTH:     sid_size_r <= cfg_wdata;
        CFG_COOKIES_ENABLED: ck_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    status_t bst;
    cur = ctx_r;
    if (record_start) begin
      cur       = '0;
      cur.phase = PH_HEADER;
    end
    ctx_nxt  = cur;
    sum_vld  = 1'b0;
    sum_st   = STAT_OK;
    ck_vld   = 1'b0;
    ck_idx   = cur.ck_len - cur.opt_left[5:0];
    rl_dec   = (cur.rdata_left != 16'd0) ? cur.rdata_left - 16'd1 : 16'd0;
    ol_dec   = (cur.opt_left != 16'd0) ? cur.opt_left - 16'd1 : 16'd0;
    full_hdr = {cur.opt_hdr, data_byte};
    opt_code = full_hdr[31:16];
    opt_len  = full_hdr[15:0];
    bst      = STAT_OK;

    unique case (cur.phase)
      PH_IDLE: ;
      PH_HEADER: begin
        ctx_nxt.hdr_cnt = cur.hdr_cnt + 4'd1;
        case (cur.hdr_cnt)
          HDR_OWNER, HDR_TYPE_HI: begin
            if (data_byte != 8'd0) begin
              sum_vld = 1'b1;
              sum_st  = STAT_NOT_EDNS;
            end
          end
          HDR_TYPE_LO: begin
            if (data_byte != TYPE_OPT_CODE) begin
              sum_vld = 1'b1;
              sum_st  = STAT_NOT_EDNS;
            end
          end
          HDR_CLASS_HI: ctx_nxt.udp = {data_byte, 8'd0};
          HDR_CLASS_LO: ctx_nxt.udp = {cur.udp[15:8], data_byte};
          HDR_VERSION:  ctx_nxt.ver_bad = (data_byte != 8'd0);
          HDR_FLAGS_HI: ctx_nxt.do_bit = data_byte[7];
          HDR_RDLEN_HI: ctx_nxt.rdata_left = {data_byte, 8'd0};
          HDR_RDLEN_LO: begin
            ctx_nxt.rdata_left = {cur.rdata_left[15:8], data_byte};
            if (cur.ver_bad) begin
              sum_vld = 1'b1;
              sum_st  = STAT_BAD_VERS;
            end else begin
              sum_vld = boundary_done(ctx_nxt.rdata_left, bst);
              sum_st  = bst;
              if (!sum_vld) begin
                ctx_nxt.phase   = PH_OPTHDR;
                ctx_nxt.opt_cnt = 2'd0;
              end
            end
          end
          default: ;
        endcase
      end
      PH_OPTHDR: begin
        ctx_nxt.opt_hdr    = {cur.opt_hdr[15:0], data_byte};
        ctx_nxt.rdata_left = rl_dec;
        ctx_nxt.opt_cnt    = cur.opt_cnt + 2'd1;
        if (cur.opt_cnt == 2'd3) begin
          ctx_nxt.is_cookie = 1'b0;
          if (opt_len > rl_dec) begin
            sum_vld = 1'b1;
            sum_st  = STAT_MALFORMED;
          end else begin
            if (opt_code == NSID_OPT_CODE) begin
              if (sid_size_r != 16'd0) begin
                ctx_nxt.nsid  = 1'b1;
                ctx_nxt.space = sat_add(cur.space,
                                        {1'b0, OPT_HEADER_LEN} + {1'b0, sid_size_r});
              end
            end else if (opt_code == COOKIE_OPT_CODE && ck_en_r) begin
              if (opt_len == COOKIE_LEN_CLIENT) begin
                ctx_nxt.ck_state = CK_INVALID;
              end else if (opt_len < COOKIE_LEN_MIN || opt_len > COOKIE_LEN_MAX) begin
                sum_vld = 1'b1;
                sum_st  = STAT_MALFORMED;
              end else begin
                ctx_nxt.ck_state = CK_UNVERIFIED;
              end
              ctx_nxt.ck_len    = opt_len[5:0];
              ctx_nxt.is_cookie = 1'b1;
              ctx_nxt.space     = sat_add(cur.space,
                                          {1'b0, OPT_HEADER_LEN + COOKIE_RESERVE});
            end
            if (!sum_vld) begin
              ctx_nxt.opt_left = opt_len;
              if (opt_len == 16'd0) begin
                sum_vld = boundary_done(rl_dec, bst);
                sum_st  = bst;
                if (!sum_vld) begin
                  ctx_nxt.phase = PH_OPTHDR;
                end
              end else begin
                ctx_nxt.phase = PH_OPTDATA;
              end
            end
          end
        end
      end
      PH_OPTDATA: begin
        ck_vld             = cur.is_cookie;
        ctx_nxt.opt_left   = ol_dec;
        ctx_nxt.rdata_left = rl_dec;
        if (ol_dec == 16'd0) begin
          sum_vld = boundary_done(rl_dec, bst);
          sum_st  = bst;
          if (!sum_vld) begin
            ctx_nxt.phase   = PH_OPTHDR;
            ctx_nxt.opt_cnt = 2'd0;
          end
        end
      end
      default: ;
    endcase

    // Truncated record: packet ends before the record does
    if (cur.phase != PH_IDLE && !sum_vld && packet_end) begin
      sum_vld = 1'b1;
      sum_st  = STAT_MALFORMED;
    end
    if (sum_vld) begin
      ctx_nxt.phase = PH_IDLE;
    end
  end

  always_comb begin
    rsv      = sat_add(ctx_nxt.space, {1'b0, RECORD_FIXED_LEN});
    sum_data = '0;
    sum_data[OFF_STATUS +: 2] = sum_st;
    if (sum_st == STAT_OK) begin
      sum_data[OFF_UDP_SIZE +: 16] = ctx_nxt.udp;
      sum_data[OFF_DO]             = ctx_nxt.do_bit;
      sum_data[OFF_NSID]           = ctx_nxt.nsid;
      sum_data[OFF_CK_STATUS +: 2] = ctx_nxt.ck_state;
      sum_data[OFF_CK_LENGTH +: 6] = ctx_nxt.ck_len;
      sum_data[OFF_RESERVED +: 16] = rsv;
    end else if (sum_st == STAT_BAD_VERS) begin
      sum_data[OFF_RESERVED +: 16] = RECORD_FIXED_LEN;
    end
    ck_data = '0;
    ck_data[OFF_CK_BYTE +: 8]  = data_byte;
    ck_data[OFF_CK_INDEX +: 6] = ck_idx;

    // Cookie byte leads when both come from one beat
    push.a_vld  = step && (ck_vld || sum_vld);
    push.b_vld  = step && ck_vld && sum_vld;
    push.a.kind = ck_vld;
    push.a.last = !(ck_vld && sum_vld);
    push.a.data = ck_vld ? ck_data : sum_data;
    push.b.kind = 1'b0;
    push.b.last = 1'b1;
    push.b.data = sum_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '0;
    end else if (step) begin
      ctx_r <= ctx_nxt;
    end
  end

  a_sum_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && sum_vld |=> ctx_r.phase == PH_IDLE)
    else $error("parser did not go idle after a summary");

  a_cookie_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    step && ck_vld |-> ctx_r.phase == PH_OPTDATA && !record_start)
    else $error("cookie byte outside option data");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    step && ctx_r.phase == PH_IDLE && !record_start |-> !push.a_vld)
    else $error("result while idle");

endmodule

[hw/rtl/eorp_out_fifo.sv]
// Four-entry result queue taking up to two results per cycle.
module eorp_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  eorp_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output eorp_pkg::res_t  out_res
);
  import eorp_pkg::*;

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               pop;

  assign room      = count_r <= FIFO_CW'(FIFO_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.a_vld) + FIFO_AW'(push.b_vld);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + FIFO_CW'(push.a_vld) + FIFO_CW'(push.b_vld) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a_vld) begin
      mem[wr_ptr_r] <= push.a;
    end
    if (push.b_vld) begin
      mem[wr_ptr_r + FIFO_AW'(1)] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.a_vld |-> room)
    else $error("push without room");

  a_pair_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    push.b_vld |-> push.a_vld && push.a.kind && !push.a.last)
    else $error("second result without a leading cookie byte");

endmodule

[hw/rtl/edns_opt_record_parser.sv]
// Top level of the EDNS OPT record parser: parse core and result queue.
//
//  channel | dir | tdata                     | tuser        | tlast
//  in_     | in  | data_byte                 | record_start | packet_end
//  out_    | out | summary / cookie fields   | kind         | last
//  cfg_    | in  | index 0 NSID length, index 1 cookie enable (write only)
//
// One input beat per cycle while in_tready is high; each beat is parsed in the cycle it is accepted.
// A beat yields zero to two results, queued in a four-entry result queue.
// in_tready drops while fewer than two queue entries are free, so a sink
// that takes one beat per cycle sustains one input beat per cycle.
// Reset is synchronous, active low, and returns the parser to idle.
module edns_opt_record_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [eorp_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                             in_tuser,   // record_start
  input  logic                             in_tlast,   // packet_end
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [17:2] max_udp_size, [18] DO bit, [19] nsid_requested,
  // [21:20] cookie state, [27:22] cookie size, [43:28] reserved_space,
  // [51:44] cookie_byte, [57:52] cookie_index, [63:58] zero
  output logic [eorp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser,  // kind
  output logic                             out_tlast,  // last
  input  logic                             cfg_we,
  input  logic [eorp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eorp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import eorp_pkg::*;

  push_t push;
  res_t  out_res;
  logic  step;

  assign step = in_tvalid && in_tready;

  eorp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (in_tdata),
    .record_start (in_tuser),
    .packet_end   (in_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push)
  );

  eorp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
